// ===== rtl/bdms_pkg.sv =====
// Shared types, constants and helpers of the bilinear density mask sampler.
package bdms_pkg;

  localparam int MASK_MAX_WIDTH_DEF  = 128;
  localparam int MASK_MAX_HEIGHT_DEF = 128;

  localparam int CRD_W = 7;
  localparam int QW    = 16 + CRD_W;
  localparam int SIZE_MIN_EXCL = 6;

  localparam logic [2:0] REG_BOUND_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOUND_MIN_Z = 3'd1;
  localparam logic [2:0] REG_BOUND_MAX_X = 3'd2;
  localparam logic [2:0] REG_BOUND_MAX_Z = 3'd3;
  localparam logic [2:0] REG_THRESHOLD   = 3'd4;
  localparam logic [2:0] REG_GAIN        = 3'd5;
  localparam logic [2:0] REG_MODE        = 3'd6;
  localparam logic [2:0] REG_MASK_DIMS   = 3'd7;

  localparam logic [2:0] CH_GREEN = 3'd1;
  localparam logic [2:0] CH_BLUE  = 3'd2;
  localparam logic [2:0] CH_ALPHA = 3'd3;
  localparam logic [2:0] CH_LUMA  = 3'd4;

  localparam int MODE_INVERT = 3;
  localparam int MODE_ENABLE = 4;

  typedef struct packed {
    logic             smp;
    logic             wr;
    logic             bad;
    logic [15:0]      rnd;
    logic [CRD_W-1:0] wx;
    logic [CRD_W-1:0] wy;
    logic [15:0]      wdata;
  } item_t;

  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] qn;
  } lane_t;

  function automatic logic [15:0] lerp16(input logic [15:0] p, input logic [15:0] q,
                                         input logic [15:0] t);
    logic [32:0] s;
    s = 33'(p) * 33'(17'h10000 - 17'(t)) + 33'(q) * 33'(t) + 33'd32768;
    return s[31:16];
  endfunction

endpackage

// ===== rtl/bilinear_density_mask_sampler_core.sv =====
// Top level: texel store, axis mapping, bilinear filter and density shaping.
//
//  channel   dir  beat carries
//  s_axis    in   one write or sample item (tuser = command)
//  m_axis    out  density and accept, one beat per sample item
//  cfg       in   one register write per cycle, no handshake
//
// One item enters per cycle unless the pipeline stalls; a sample result leaves after
// the 23-stage quotient pipeline plus the address, filter and gain stages.
// Texel writes land in the same stage where samples read, so order is kept.
// Stall: the whole pipeline holds while a result waits on m_axis.
// Reset clears valid bits and configuration registers; the texel store is not cleared.
module bilinear_density_mask_sampler_core #(
  parameter int MASK_MAX_WIDTH  = bdms_pkg::MASK_MAX_WIDTH_DEF,
  parameter int MASK_MAX_HEIGHT = bdms_pkg::MASK_MAX_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // world_x, world_z, random_value, texel_x, texel_y, red, green, blue, alpha
  input  logic [127:0] s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // density, accept
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import bdms_pkg::*;

  localparam int BC    = (MASK_MAX_WIDTH + 1) / 2;
  localparam int BR    = (MASK_MAX_HEIGHT + 1) / 2;
  localparam int DEPTH = BC * BR;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic signed [31:0] bminx_q, bminz_q, bmaxx_q, bmaxz_q;
  logic [15:0] thr_q, gain_q;
  logic [4:0]  mode_q;
  logic [13:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bminx_q <= '0; bminz_q <= '0; bmaxx_q <= '0; bmaxz_q <= '0;
      thr_q <= '0; gain_q <= 16'd256; mode_q <= '0; dims_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOUND_MIN_X: bminx_q <= cfg_wdata_i;
        REG_BOUND_MIN_Z: bminz_q <= cfg_wdata_i;
        REG_BOUND_MAX_X: bmaxx_q <= cfg_wdata_i;
        REG_BOUND_MAX_Z: bmaxz_q <= cfg_wdata_i;
        REG_THRESHOLD:   thr_q   <= cfg_wdata_i[15:0];
        REG_GAIN:        gain_q  <= cfg_wdata_i[15:0];
        REG_MODE:        mode_q  <= cfg_wdata_i[4:0];
        REG_MASK_DIMS:   dims_q  <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // derived bounds
  logic signed [31:0] lox_q, loz_q;
  logic [31:0]        sx_q, sz_q;
  logic               deg_q;
  logic [CRD_W-1:0]   topx_q, topz_q;

  always_ff @(posedge clk_i) begin
    logic [31:0] sx, sz;
    sx = (bminx_q < bmaxx_q) ? 32'(bmaxx_q - bminx_q) : 32'(bminx_q - bmaxx_q);
    sz = (bminz_q < bmaxz_q) ? 32'(bmaxz_q - bminz_q) : 32'(bminz_q - bmaxz_q);
    lox_q  <= (bminx_q < bmaxx_q) ? bminx_q : bmaxx_q;
    loz_q  <= (bminz_q < bmaxz_q) ? bminz_q : bmaxz_q;
    sx_q   <= sx;
    sz_q   <= sz;
    deg_q  <= (sx <= 32'(SIZE_MIN_EXCL)) || (sz <= 32'(SIZE_MIN_EXCL));
    topx_q <= (32'(dims_q[6:0]) > 32'(MASK_MAX_WIDTH - 1)) ?
              CRD_W'(MASK_MAX_WIDTH - 1) : dims_q[6:0];
    topz_q <= (32'(dims_q[13:7]) > 32'(MASK_MAX_HEIGHT - 1)) ?
              CRD_W'(MASK_MAX_HEIGHT - 1) : dims_q[13:7];
  end

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: input beat
  logic              s1_vld_q, s1_smp_q;
  logic signed [31:0] s1_wx_q, s1_wz_q;
  logic [15:0]       s1_rnd_q;
  logic [CRD_W-1:0]  s1_tx_q, s1_ty_q;
  logic [7:0]        s1_r_q, s1_g_q, s1_b_q, s1_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_smp_q <= s_axis_tuser;
      s1_wx_q  <= s_axis_tdata[31:0];
      s1_wz_q  <= s_axis_tdata[63:32];
      s1_rnd_q <= s_axis_tdata[79:64];
      s1_tx_q  <= s_axis_tdata[86:80];
      s1_ty_q  <= s_axis_tdata[93:87];
      s1_r_q   <= s_axis_tdata[101:94];
      s1_g_q   <= s_axis_tdata[109:102];
      s1_b_q   <= s_axis_tdata[117:110];
      s1_a_q   <= s_axis_tdata[125:118];
    end
  end

  // stage 2: texel conversion, weighted luma sum
  logic              s2_vld_q, s2_smp_q, s2_luma_q;
  logic signed [31:0] s2_wx_q, s2_wz_q;
  logic [15:0]       s2_rnd_q, s2_wval_q;
  logic [CRD_W-1:0]  s2_tx_q, s2_ty_q;
  logic [23:0]       s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_smp_q <= s1_smp_q;
      s2_wx_q  <= s1_wx_q;
      s2_wz_q  <= s1_wz_q;
      s2_rnd_q <= s1_rnd_q;
      s2_tx_q  <= s1_tx_q;
      s2_ty_q  <= s1_ty_q;
      s2_sum_q <= 24'(24'd13933 * 24'(s1_r_q) + 24'd46871 * 24'(s1_g_q)
                    + 24'd4732 * 24'(s1_b_q));
      s2_luma_q <= (mode_q[2:0] == CH_LUMA);
      case (mode_q[2:0])
        CH_GREEN: s2_wval_q <= {s1_g_q, s1_g_q};
        CH_BLUE:  s2_wval_q <= {s1_b_q, s1_b_q};
        CH_ALPHA: s2_wval_q <= {s1_a_q, s1_a_q};
        default:  s2_wval_q <= {s1_r_q, s1_r_q};
      endcase
    end
  end

  // stage 3: offsets into the bounds
  logic        s3_vld_q;
  item_t       s3_item_q;
  logic [31:0] s3_dx_q, s3_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [32:0] dx, dz;
    logic [31:0]        lp;
    if (en) begin
      dx = 33'(s2_wx_q) - 33'(lox_q);
      dz = 33'(s2_wz_q) - 33'(loz_q);
      lp = 32'((33'(s2_sum_q) * 33'd257) >> 16);
      s3_dx_q <= dx[31:0];
      s3_dz_q <= dz[31:0];
      s3_item_q.smp   <= s2_smp_q;
      s3_item_q.wr    <= !s2_smp_q;
      s3_item_q.bad   <= deg_q || dx[32] || dz[32] ||
                         (dx[31:0] > sx_q) || (dz[31:0] > sz_q);
      s3_item_q.rnd   <= s2_rnd_q;
      s3_item_q.wx    <= s2_tx_q;
      s3_item_q.wy    <= s2_ty_q;
      s3_item_q.wdata <= s2_luma_q ? lp[15:0] : s2_wval_q;
    end
  end

  // stage 4: dividend setup
  logic        s4_vld_q;
  item_t       s4_item_q;
  lane_t [1:0] s4_lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (en) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    logic [38:0] px, pz;
    if (en) begin
      px = 39'(s3_dx_q) * 39'(topx_q);
      pz = 39'(s3_dz_q) * 39'(topz_q);
      s4_item_q <= s3_item_q;
      s4_lane_q[0].rem <= px[38:7];
      s4_lane_q[0].qn  <= {px[6:0], 16'h0000};
      s4_lane_q[1].rem <= pz[38:7];
      s4_lane_q[1].qn  <= {pz[6:0], 16'h0000};
    end
  end

  logic                 dv_vld;
  item_t                dv_item;
  logic [1:0][QW-1:0]   dv_quot;
  logic [1:0][31:0]     dv_size;

  assign dv_size[0] = sx_q;
  assign dv_size[1] = sz_q;

  bdms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .item_i  (s4_item_q),
    .lane_i  (s4_lane_q),
    .size_i  (dv_size),
    .valid_o (dv_vld),
    .item_o  (dv_item),
    .quot_o  (dv_quot)
  );

  // texel coordinates and banked store access
  logic [CRD_W-1:0] x0, x1, y0, y1;
  logic [15:0]      fx, fy;

  always_comb begin
    x0 = dv_quot[0][QW-1:16];
    fx = dv_quot[0][15:0];
    if (x0 > topx_q) begin
      x0 = topx_q;
      fx = '0;
    end
    x1 = (x0 >= topx_q) ? topx_q : CRD_W'(x0 + 1'b1);
    y0 = dv_quot[1][QW-1:16];
    fy = dv_quot[1][15:0];
    if (y0 > topz_q) begin
      y0 = topz_q;
      fy = '0;
    end
    y1 = (y0 >= topz_q) ? topz_q : CRD_W'(y0 + 1'b1);
  end

  logic          wr_ok;
  logic [1:0]    wr_bank;
  logic [AW-1:0] wr_addr;

  assign wr_ok   = dv_vld && dv_item.wr && en &&
                   (32'(dv_item.wx) < 32'(MASK_MAX_WIDTH)) &&
                   (32'(dv_item.wy) < 32'(MASK_MAX_HEIGHT));
  assign wr_bank = {dv_item.wy[0], dv_item.wx[0]};
  assign wr_addr = AW'(32'(dv_item.wy[CRD_W-1:1]) * 32'(BC) + 32'(dv_item.wx[CRD_W-1:1]));

  logic [15:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [15:0]      mem_q [DEPTH];
    logic [CRD_W-1:0] col, row;
    logic [AW-1:0]    raddr;

    assign col   = (x0[0] == b[0]) ? x0 : x1;
    assign row   = (y0[0] == b[1]) ? y0 : y1;
    assign raddr = AW'(32'(row[CRD_W-1:1]) * 32'(BC) + 32'(col[CRD_W-1:1]));

    always_ff @(posedge clk_i) begin
      if (wr_ok && (wr_bank == 2'(b))) begin
        mem_q[wr_addr] <= dv_item.wdata;
      end
      if (en) begin
        rd_q[b] <= mem_q[raddr];
      end
    end
  end

  logic       rd_vld_q;
  item_t      rd_item_q;
  logic [15:0] rd_fx_q, rd_fy_q;
  logic       rd_x0p_q, rd_x1p_q, rd_y0p_q, rd_y1p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else if (en) rd_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_item_q <= dv_item;
      rd_fx_q   <= fx;
      rd_fy_q   <= fy;
      rd_x0p_q  <= x0[0];
      rd_x1p_q  <= x1[0];
      rd_y0p_q  <= y0[0];
      rd_y1p_q  <= y1[0];
    end
  end

  // filter along x, then along y
  logic        l1_vld_q;
  item_t       l1_item_q;
  logic [15:0] l1_a_q, l1_b_q, l1_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l1_vld_q <= 1'b0;
    else if (en) l1_vld_q <= rd_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_item_q <= rd_item_q;
      l1_fy_q   <= rd_fy_q;
      l1_a_q    <= lerp16(rd_q[{rd_y0p_q, rd_x0p_q}], rd_q[{rd_y0p_q, rd_x1p_q}], rd_fx_q);
      l1_b_q    <= lerp16(rd_q[{rd_y1p_q, rd_x0p_q}], rd_q[{rd_y1p_q, rd_x1p_q}], rd_fx_q);
    end
  end

  logic        l2_vld_q;
  item_t       l2_item_q;
  logic [15:0] l2_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l2_vld_q <= 1'b0;
    else if (en) l2_vld_q <= l1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    logic [15:0] d;
    if (en) begin
      d = lerp16(l1_a_q, l1_b_q, l1_fy_q);
      l2_item_q <= l1_item_q;
      l2_d_q    <= mode_q[MODE_INVERT] ? 16'(16'hFFFF - d) : d;
    end
  end

  logic        l3_vld_q;
  item_t       l3_item_q;
  logic [31:0] l3_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l3_vld_q <= 1'b0;
    else if (en) l3_vld_q <= l2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l3_item_q <= l2_item_q;
      l3_g_q    <= 32'(l2_d_q) * 32'(gain_q);
    end
  end

  // saturate, threshold, special cases
  logic [15:0] out_dens_q;
  logic        out_acc_q;
  logic [15:0] dens;

  always_comb begin
    logic [15:0] s;
    s = (l3_g_q[31:24] != 8'h00) ? 16'hFFFF : l3_g_q[23:8];
    if (!mode_q[MODE_ENABLE]) begin
      dens = 16'hFFFF;
    end else if (l3_item_q.bad || (s < thr_q)) begin
      dens = '0;
    end else begin
      dens = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= l3_vld_q && l3_item_q.smp;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dens_q <= dens;
      out_acc_q  <= (l3_item_q.rnd <= dens);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_acc_q, out_dens_q};

endmodule

// ===== rtl/bdms_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two axis lanes.
module bdms_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  bdms_pkg::item_t                     item_i,
  input  bdms_pkg::lane_t [1:0]               lane_i,
  input  logic [1:0][31:0]                    size_i,
  output logic                                valid_o,
  output bdms_pkg::item_t                     item_o,
  output logic [1:0][bdms_pkg::QW-1:0]        quot_o
);
  import bdms_pkg::*;

  logic         vld_q  [QW];
  item_t        item_q [QW];
  lane_t [1:0]  lane_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic        src_vld;
    item_t       src_item;
    lane_t [1:0] src_lane;
    lane_t [1:0] lane_d;

    if (k == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_item = item_i;
      assign src_lane = lane_i;
    end else begin : g_next
      assign src_vld  = vld_q[k-1];
      assign src_item = item_q[k-1];
      assign src_lane = lane_q[k-1];
    end

    always_comb begin
      logic [32:0] r2;
      logic        qb;
      for (int j = 0; j < 2; j++) begin
        r2 = {src_lane[j].rem, src_lane[j].qn[QW-1]};
        qb = (r2 >= {1'b0, size_i[j]});
        if (qb) begin
          lane_d[j].rem = 32'(r2 - {1'b0, size_i[j]});
        end else begin
          lane_d[j].rem = r2[31:0];
        end
        lane_d[j].qn = {src_lane[j].qn[QW-2:0], qb};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= src_item;
        lane_q[k] <= lane_d;
      end
    end
  end

  assign valid_o   = vld_q[QW-1];
  assign item_o    = item_q[QW-1];
  assign quot_o[0] = lane_q[QW-1][0].qn;
  assign quot_o[1] = lane_q[QW-1][1].qn;

endmodule

// ===== verif/bdms_checker.sv =====
// Checker for the density mask sampler: mirrors config and texels, predicts and compares results.
module bdms_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdms_pkg::*;

  typedef struct packed {
    logic        accept;
    logic [15:0] density;
  } sample_res_t;

  logic [31:0] bnd_a_x, bnd_a_z, bnd_b_x, bnd_b_z;
  logic [15:0] thresh, gain;
  logic [4:0]  mode;
  logic [13:0] dims;
  logic [15:0] texels [16384];
  sample_res_t density_q [$];
  int          errors;
  int          pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [15:0] lerp(input longint p, input longint q, input longint t);
    return 16'((p * (65536 - t) + q * t + 32768) >>> 16);
  endfunction

  function automatic bit map_axis(input longint pt, input longint lo, input longint size,
                                  input int dim, output int i0, output int i1,
                                  output longint fr);
    longint d, p;
    int     top;
    top = dim - 1;
    d   = pt - lo;
    i0 = 0; i1 = 0; fr = 0;
    if (d < 0 || d > size) return 0;
    p  = ((d * top) <<< 16) / size;
    i0 = int'(p >>> 16);
    fr = p & 64'hFFFF;
    if (i0 > top) begin
      i0 = top;
      fr = 0;
    end
    i1 = (i0 + 1 > top) ? top : i0 + 1;
    return 1;
  endfunction

  function automatic logic [15:0] sample_density(input logic [31:0] px, input logic [31:0] pz);
    longint ax, az, bx, bz, lox, loz, sx, sz, tx, tz, g;
    int     x0, x1, z0, z1, w, h;
    logic [15:0] ra, rb, d;
    ax = longint'(signed'(bnd_a_x)); bx = longint'(signed'(bnd_b_x));
    az = longint'(signed'(bnd_a_z)); bz = longint'(signed'(bnd_b_z));
    lox = ax < bx ? ax : bx;
    loz = az < bz ? az : bz;
    sx = (ax < bx ? bx : ax) - lox;
    sz = (az < bz ? bz : az) - loz;
    w = int'(dims[6:0]) + 1;
    h = int'(dims[13:7]) + 1;
    if (!mode[MODE_ENABLE]) return 16'hFFFF;
    if (sx <= SIZE_MIN_EXCL || sz <= SIZE_MIN_EXCL) return 16'd0;
    if (!map_axis(longint'(signed'(px)), lox, sx, w, x0, x1, tx)) return 16'd0;
    if (!map_axis(longint'(signed'(pz)), loz, sz, h, z0, z1, tz)) return 16'd0;
    ra = lerp(texels[z0*128+x0], texels[z0*128+x1], tx);
    rb = lerp(texels[z1*128+x0], texels[z1*128+x1], tx);
    d  = lerp(ra, rb, tz);
    if (mode[MODE_INVERT]) d = 16'hFFFF - d;
    g = (longint'(d) * longint'(gain)) >>> 8;
    d = g > 65535 ? 16'hFFFF : 16'(g);
    return d >= thresh ? d : 16'd0;
  endfunction

  function automatic logic [15:0] texel_density(input logic [7:0] r, input logic [7:0] gr,
                                                input logic [7:0] bl, input logic [7:0] al);
    longint l;
    case (mode[2:0])
      CH_GREEN: return 16'(gr * 257);
      CH_BLUE:  return 16'(bl * 257);
      CH_ALPHA: return 16'(al * 257);
      CH_LUMA: begin
        l = (13933 * longint'(r) + 46871 * longint'(gr) + 4732 * longint'(bl)) * 257;
        return 16'(l >>> 16);
      end
      default:  return 16'(r * 257);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_res_t exp_r, got;
    logic [15:0] dn;
    if (!rst_ni) begin
      bnd_a_x <= '0; bnd_a_z <= '0; bnd_b_x <= '0; bnd_b_z <= '0;
      thresh <= '0; gain <= 16'd256; mode <= '0; dims <= '0;
      errors = 0;
      density_q.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOUND_MIN_X: bnd_a_x <= cfg_wdata_i;
          REG_BOUND_MIN_Z: bnd_a_z <= cfg_wdata_i;
          REG_BOUND_MAX_X: bnd_b_x <= cfg_wdata_i;
          REG_BOUND_MAX_Z: bnd_b_z <= cfg_wdata_i;
          REG_THRESHOLD:   thresh  <= cfg_wdata_i[15:0];
          REG_GAIN:        gain    <= cfg_wdata_i[15:0];
          REG_MODE:        mode    <= cfg_wdata_i[4:0];
          default:         dims    <= cfg_wdata_i[13:0];
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          dn = sample_density(s_axis_tdata[31:0], s_axis_tdata[63:32]);
          exp_r.density = dn;
          exp_r.accept  = s_axis_tdata[79:64] <= dn;
          density_q.push_back(exp_r);
        end else begin
          texels[s_axis_tdata[93:87]*128 + s_axis_tdata[86:80]] =
            texel_density(s_axis_tdata[101:94], s_axis_tdata[109:102],
                          s_axis_tdata[117:110], s_axis_tdata[125:118]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[16:0];
        if (density_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_r = density_q.pop_front();
          if (got.density !== exp_r.density)
            report($sformatf("density %h, expected %h", got.density, exp_r.density));
          if (got.accept !== exp_r.accept)
            report($sformatf("accept %b, expected %b", got.accept, exp_r.accept));
        end
      end
      pending = density_q.size();
    end
  end
endmodule

// ===== verif/tb_bilinear_density_mask_sampler_core.sv =====
// Testbench top: drives texel writes, samples and config, and gives the verdict.
module tb_bilinear_density_mask_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bdms_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  int           errors, pending;
  int           gap_pct = 0, stall_pct = 0;
  longint       ax, az, bx, bz;

  always #5 clk_i = ~clk_i;

  bilinear_density_mask_sampler_core uut (.*);

  bdms_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) m_axis_tready <= $urandom_range(99) >= stall_pct;

  task automatic send_beat(input logic cmd, input logic [127:0] data);
    bit hs;
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    forever begin
      @(negedge clk_i);
      hs = s_axis_tready;
      @(posedge clk_i);
      if (hs) break;
    end
  endtask

  task automatic write_texel(input int x, input int y, input logic [31:0] rgba);
    send_beat(1'b0, {2'b0, rgba, 7'(y), 7'(x), 80'd0});
  endtask

  task automatic sample_at(input logic [31:0] px, input logic [31:0] pz,
                           input logic [15:0] rnd);
    send_beat(1'b1, {48'd0, rnd, pz, px});
  endtask

  function automatic logic [31:0] pick_coord(input longint a, input longint b);
    longint lo, hi;
    int     r;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    r  = $urandom_range(99);
    if (r < 70) return 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
    if (r < 78) return 32'(lo);
    if (r < 86) return 32'(hi);
    if (r < 90) return 32'(lo - 1);
    if (r < 94) return 32'(hi + 1);
    return $urandom;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input int ph);
    longint lo, sz;
    logic [4:0] md;
    case (ph)
      0: begin ax = 0; bx = 8 <<< 16; az = 3 <<< 16; bz = -(5 <<< 16); end
      1: begin ax = 2147483647; bx = -2147483647 - 1; az = -2147483647 - 1; bz = 2147483647; end
      2: begin ax = 100; bx = 106; az = 0; bz = 1 <<< 16; end
      default: begin
        lo = longint'($urandom_range(1 << 25)) - (1 << 24);
        case ($urandom_range(2))
          0: sz = 7;
          1: sz = $urandom_range(1 << 24, 8);
          default: sz = $urandom_range(32'h7FFF_FFFF, 8);
        endcase
        ax = lo; bx = lo + sz;
        lo = longint'($urandom_range(1 << 25)) - (1 << 24);
        sz = $urandom_range(3) == 0 ? 7 : $urandom_range(1 << 22, 8);
        az = lo; bz = lo + sz;
        if ($urandom_range(1)) begin lo = ax; ax = bx; bx = lo; end
        if ($urandom_range(1)) begin lo = az; az = bz; bz = lo; end
      end
    endcase
    md = {ph != 5, ph == 1 ? 1'b1 : 1'($urandom_range(1)), 3'(ph)};
    if (ph == 0) md = {2'b10, CH_LUMA};
    wait_drained();
    set_reg(REG_BOUND_MIN_X, 32'(ax));
    set_reg(REG_BOUND_MIN_Z, 32'(az));
    set_reg(REG_BOUND_MAX_X, 32'(bx));
    set_reg(REG_BOUND_MAX_Z, 32'(bz));
    set_reg(REG_THRESHOLD, ph == 1 ? 32'hFFFF : ph == 0 ? 32'd0 : $urandom_range(20000));
    set_reg(REG_GAIN, ph == 1 ? 32'hFFFF : ph == 3 ? 32'd0 :
                      ph == 6 ? $urandom_range(65535) : $urandom_range(1024, 128));
    set_reg(REG_MODE, 32'(md));
    // texels are preset in a 16x16 corner plus all of row 0 and column 0
    set_reg(REG_MASK_DIMS, ph == 1 ? 32'({7'd15, 7'd15}) : ph == 0 ? 32'd0 :
                           ph == 7 ? 32'd127 : ph == 8 ? 32'({7'd127, 7'd0}) :
                           32'({7'($urandom_range(15)), 7'($urandom_range(15))}));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int y = 0; y < 128; y++)
      for (int x = 0; x < 128; x++)
        if ((x < 16 && y < 16) || x == 0 || y == 0)
          write_texel(x, y, $urandom);
    configure(0);
    write_texel(0, 0, 32'hFFFF_FFFF);
    write_texel(127, 127, 32'h0);
    sample_at(32'(ax), 32'(az), 16'd0);
    sample_at(32'(bx), 32'(bz), 16'hFFFF);
    sample_at(32'(4 <<< 16), 32'(-1 <<< 16), 16'h8000);
    sample_at(32'(ax - 1), 32'(az), 16'd0);
    sample_at(32'(bx + 1), 32'(az), 16'd0);
    sample_at(32'(ax), 32'(bz - 1), 16'd0);
    sample_at(32'(ax), 32'(az + 1), 16'd0);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    for (int i = 0; i < 8; i++)
      sample_at(pick_coord(ax, bx), pick_coord(az, bz), $urandom);
    for (int ph = 1; ph < 10; ph++) begin
      configure(ph);
      gap_pct   = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 15 : 45) : 0;
      stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 15 : 45) : 0;
      for (int i = 0; i < 120; i++) begin
        if (ph == 4 && i == 60) wait_drained();
        if ($urandom_range(99) < 25)
          write_texel($urandom_range(127), $urandom_range(127), $urandom);
        else
          sample_at(pick_coord(ax, bx), pick_coord(az, bz), $urandom);
      end
    end
    wait_drained();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bdms_pkg.sv
rtl/bdms_div.sv
rtl/bilinear_density_mask_sampler_core.sv
verif/bdms_checker.sv
verif/tb_bilinear_density_mask_sampler_core.sv
